FILE: rtl/sorted_min_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted minimum priority queue
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication
`define SMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/smpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

	localparam int KEY_W        = 32;
	localparam int DEF_CAPACITY = 64;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} smpq_ctl_t;

endpackage

FILE: rtl/smpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted key row: compares its key to the incoming key,
// shifts up on insert and down on removal.
// ----------------------------------------------------------------------------
module smpq_cell
	import smpq_pkg::*;
(
	input  logic             clk,
	input  smpq_ctl_t        ctl,
	input  logic [KEY_W-1:0] ins_key,
	input  logic             occupied,
	input  logic             left_place,
	input  logic [KEY_W-1:0] left_key,
	input  logic [KEY_W-1:0] right_key,
	output logic             place,
	output logic [KEY_W-1:0] key
);

	logic [KEY_W-1:0] key_q;

	// Empty slots count as larger than any key
	assign place = occupied ? (key_q > ins_key) : 1'b1;
	assign key   = key_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && place) begin
			key_q <= left_place ? left_key : ins_key;
		end else if (ctl.rem) begin
			key_q <= right_key;
		end
	end

endmodule

FILE: rtl/sorted_min_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Bounded minimum priority queue kept as a sorted row of key cells.
// ----------------------------------------------------------------------------
// Each transaction is an insert of a UQ16.16 key or a removal of the smallest
// key; every one yields exactly one result, registered and shown in the cycle
// after acceptance. The queue takes one transaction per cycle while the result
// is drained: every cell compares its own key with the incoming key in parallel
// and moves a key one place along the row, so the cost of a request does not
// depend on occupancy. in_ready is high whenever the result register is empty
// or being drained by out_ready in the same cycle. Inserts go in after equal
// keys; an insert into a full queue is dropped and flagged, a removal from an
// empty queue returns 0 with was_empty set.
module sorted_min_priority_queue_core
	import smpq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [KEY_W-1:0] key,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [KEY_W-1:0] removed_key,
	output logic             was_empty,
	output logic             dropped_full,
	output logic [CNT_W-1:0] occupancy
);

	logic             accept;
	logic             full;
	logic             empty;
	logic             is_insert;
	smpq_ctl_t        ctl;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             out_valid_q;
	logic [KEY_W-1:0] removed_key_q;
	logic             was_empty_q;
	logic             dropped_full_q;

	logic [CAPACITY-1:0] place;
	logic [KEY_W-1:0]    cell_key [CAPACITY];

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign is_insert = (req_type == REQ_INSERT);

	assign ctl.ins = accept && is_insert && !full;
	assign ctl.rem = accept && !is_insert && !empty;

	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             occ;
		logic             lp;
		logic [KEY_W-1:0] lk;
		logic [KEY_W-1:0] rk;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign lp = 1'b0;
			assign lk = '0;
		end else begin : g_mid
			assign lp = place[i-1];
			assign lk = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rk = '0;
		end else begin : g_inner
			assign rk = cell_key[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.ins_key    (key),
			.occupied   (occ),
			.left_place (lp),
			.left_key   (lk),
			.right_key  (rk),
			.place      (place[i]),
			.key        (cell_key[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_key_q  <= ctl.rem ? cell_key[0] : '0;
			was_empty_q    <= !is_insert && empty;
			dropped_full_q <= is_insert && full;
		end
	end

	assign out_valid    = out_valid_q;
	assign removed_key  = removed_key_q;
	assign was_empty    = was_empty_q;
	assign dropped_full = dropped_full_q;
	assign occupancy    = count_q;

endmodule

FILE: rtl/smpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_min_priority_queue_core_defines.svh"

module smpq_checker
	import smpq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [KEY_W-1:0] removed_key,
	input logic             was_empty,
	input logic             dropped_full,
	input logic [CNT_W-1:0] occupancy
);

	`SMPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(removed_key), "result changed while stalled")
	`SMPQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "no result after accepted transaction")
	`SMPQ_ASSERT_NOW(a_drop_flags, out_valid && dropped_full, removed_key == '0 && !was_empty && occupancy == CNT_W'(CAPACITY), "bad dropped insert result")
	`SMPQ_ASSERT_NOW(a_empty_flags, out_valid && was_empty, removed_key == '0 && !dropped_full && occupancy == '0, "bad empty removal result")
	`SMPQ_ASSERT_NOW(a_occ_bound, out_valid, occupancy <= CNT_W'(CAPACITY), "occupancy above capacity")

endmodule

bind sorted_min_priority_queue_core smpq_checker #(.CAPACITY(CAPACITY)) u_smpq_checker (.*);

FILE: verif/sorted_min_priority_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core_test
// Self-checking bench for the sorted minimum priority queue core.
// ----------------------------------------------------------------------------
// Drives insert and remove transactions over the valid/ready input channel
// and checks every result against a queue-based prediction of the sorted key
// store, or against the result a typed table row gives. A short table covers
// the key extremes, equal keys and removal from an empty queue. Random segments
// follow. Some lean toward inserts to reach the full queue and dropped inserts,
// others lean toward removals to drain it, and the rest are mixed. Both channels
// idle in random bursts, except over the final stretch of the run.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core_test;
	import smpq_pkg::*;

	localparam int OCC_W      = $clog2(DEF_CAPACITY + 1);
	localparam int N_RANDOM   = 1000;
	localparam int N_CALM     = 150;
	localparam int N_DIRECTED = 21;

	typedef struct packed {
		logic [KEY_W-1:0] removed;
		logic             empty;
		logic             dropped;
		logic [OCC_W-1:0] occ;
	} pq_result_t;

	typedef struct packed {
		req_t             req;
		logic [KEY_W-1:0] key;
		logic             typed;
		pq_result_t       res;
	} dir_row_t;

	localparam pq_result_t NO_RES = '{32'h0, 1'b0, 1'b0, 7'd0};

	localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
		'{REQ_REMOVE, 32'hDEADBEEF, 1'b1, '{32'h0, 1'b1, 1'b0, 7'd0}},
		'{REQ_INSERT, 32'hFFFFFFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd1}},
		'{REQ_INSERT, 32'h00000000, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd2}},
		'{REQ_INSERT, 32'h00010000, 1'b0, NO_RES},
		'{REQ_INSERT, 32'h00010000, 1'b0, NO_RES},
		'{REQ_INSERT, 32'h0000FFFF, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'hFFFFFFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 7'd4}},
		'{REQ_REMOVE, 32'h00000000, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'h12345678, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'h00000000, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'h00000000, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b0, 7'd0}},
		'{REQ_REMOVE, 32'hFFFFFFFF, 1'b1, '{32'h0, 1'b1, 1'b0, 7'd0}},
		'{REQ_INSERT, 32'h80000000, 1'b0, NO_RES},
		'{REQ_INSERT, 32'h7FFFFFFF, 1'b0, NO_RES},
		'{REQ_INSERT, 32'h55555555, 1'b0, NO_RES},
		'{REQ_INSERT, 32'hAAAAAAAA, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'hFFFFFFFF, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'h00000000, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'hA5A5A5A5, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'h00000000, 1'b0, NO_RES},
		'{REQ_REMOVE, 32'h00000000, 1'b1, '{32'h0, 1'b1, 1'b0, 7'd0}}
	};

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_ready;
	logic             req_type     = 1'b0;
	logic [KEY_W-1:0] key          = '0;
	logic             out_valid;
	logic             out_ready    = 1'b0;
	logic [KEY_W-1:0] removed_key;
	logic             was_empty;
	logic             dropped_full;
	logic [OCC_W-1:0] occupancy;

	logic [KEY_W-1:0] shadow_keys [$];
	pq_result_t       expected_results [$];
	int               errors = 0;
	bit               calm   = 1'b0;
	bit               gappy  = 1'b1;

	sorted_min_priority_queue_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.key          (key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_key  (removed_key),
		.was_empty    (was_empty),
		.dropped_full (dropped_full),
		.occupancy    (occupancy)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("sorted_min_priority_queue_core test failed");
		$finish;
	end

	// Present one transaction, hold it until accepted, then update the shadow store.
	task automatic issue_request(input req_t r, input logic [KEY_W-1:0] k, input logic typed,
			input pq_result_t typed_res);
		pq_result_t res;
		int         pos;
		in_valid <= 1'b1;
		req_type <= r;
		key      <= k;
		do @(posedge clk); while (!in_ready);
		res = '0;
		if (r == REQ_INSERT) begin
			if (shadow_keys.size() >= DEF_CAPACITY) begin
				res.dropped = 1'b1;
			end else begin
				pos = 0;
				while (pos < shadow_keys.size() && shadow_keys[pos] <= k) pos++;
				shadow_keys.insert(pos, k);
			end
		end else if (shadow_keys.size() == 0) begin
			res.empty = 1'b1;
		end else begin
			res.removed = shadow_keys.pop_front();
		end
		res.occ = OCC_W'(shadow_keys.size());
		expected_results.push_back(typed ? typed_res : res);
		if (!calm && gappy && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 5))
			0: return KEY_W'($urandom_range(0, 7));
			1: return 32'hFFFFFFF8 | KEY_W'($urandom_range(0, 7));
			2: return {16'($urandom_range(0, 3)), 16'h0000};
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int   seg_left;
		int   ins_pct;
		int   seg_no;
		int   spins;
		req_t r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			issue_request(DIR_ROWS[i].req, DIR_ROWS[i].key, DIR_ROWS[i].typed, DIR_ROWS[i].res);
		end

		seg_left = 0;
		ins_pct  = 50;
		seg_no   = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (seg_left == 0) begin
				// fill to capacity first, drain to empty second, then mix
				if (seg_no == 0) begin
					seg_left = 100;
					ins_pct  = 95;
				end else if (seg_no == 1) begin
					seg_left = 100;
					ins_pct  = 5;
				end else begin
					seg_left = $urandom_range(20, 90);
					case ($urandom_range(0, 3))
						0: ins_pct = 90;
						1: ins_pct = 10;
						default: ins_pct = 50;
					endcase
				end
				gappy = $urandom_range(0, 2) != 0;
				seg_no++;
			end
			seg_left--;
			if (i >= N_RANDOM - N_CALM) calm = 1'b1;
			r = ($urandom_range(1, 100) <= ins_pct) ? REQ_INSERT : REQ_REMOVE;
			issue_request(r, pick_key(), 1'b0, NO_RES);
		end
		in_valid <= 1'b0;

		spins = 0;
		while (expected_results.size() != 0 && spins < 2000) begin
			@(posedge clk);
			spins++;
		end
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			errors++;
		end
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("sorted_min_priority_queue_core test passed");
		end else begin
			$display("sorted_min_priority_queue_core test failed");
		end
		$finish;
	end

	// Stall the result channel in bursts, except over the calm tail.
	initial begin
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		pq_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result removed_key %h occupancy %0d", $time,
					removed_key, occupancy);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (removed_key !== want.removed) begin
					$display("%0t: removed_key expected %h got %h", $time, want.removed,
						removed_key);
					errors++;
				end
				if (was_empty !== want.empty) begin
					$display("%0t: was_empty expected %b got %b", $time, want.empty, was_empty);
					errors++;
				end
				if (dropped_full !== want.dropped) begin
					$display("%0t: dropped_full expected %b got %b", $time, want.dropped,
						dropped_full);
					errors++;
				end
				if (occupancy !== want.occ) begin
					$display("%0t: occupancy expected %0d got %0d", $time, want.occ, occupancy);
					errors++;
				end
			end
		end
	end

endmodule
